### hw/rtl/sfr_pkg.sv
// Shared types and constants for the serial frame receiver.
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int BYTE_W = 8;
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_HEADER = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TYPE = 8'd1;

   localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h05;
   localparam logic [BYTE_W-1:0] TYPE_RESET = 8'h5b;

   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_HEADER = 3'd0;
   localparam logic [OP_W-1:0] OP_TYPE = 3'd1;
   localparam logic [OP_W-1:0] OP_LEN_LO = 3'd2;
   localparam logic [OP_W-1:0] OP_LEN_HI = 3'd3;
   localparam logic [OP_W-1:0] OP_DATA = 3'd4;
   localparam logic [OP_W-1:0] OP_CHECK = 3'd5;

   typedef struct packed {
      logic take;
      logic [OP_W-1:0] op;
      logic rd_go;
   } cmd_type;

   typedef struct packed {
      logic header_hit;
      logic type_hit;
      logic len_bad;
      logic len_one;
      logic data_last;
      logic sum_hit;
      logic rd_last;
   } status_type;

endpackage

### hw/rtl/sfr_if.sv
// Handshake channel interfaces for received bytes, frame words and register writes.
`timescale 1ns / 1ps

interface sfr_req_if;
   logic valid;
   logic ready;
   logic [sfr_pkg::BYTE_W-1:0] rx_byte;
   modport source(output valid, output rx_byte, input ready);
   modport sink(input valid, input rx_byte, output ready);
endinterface

interface sfr_rsp_if;
   logic valid;
   logic ready;
   logic [sfr_pkg::BYTE_W-1:0] frame_byte;
   logic frame_last;
   modport source(output valid, output frame_byte, output frame_last, input ready);
   modport sink(input valid, input frame_byte, input frame_last, output ready);
endinterface

interface sfr_csr_if;
   logic valid;
   logic ready;
   logic [sfr_pkg::CSR_IDX_W-1:0] reg_index;
   logic [sfr_pkg::BYTE_W-1:0] wr_data;
   modport source(output valid, output reg_index, output wr_data, input ready);
   modport sink(input valid, input reg_index, input wr_data, output ready);
endinterface

### hw/rtl/serial_frame_receiver_checksum_core.sv
// Top level of the serial frame receiver with additive checksum.
//
//   Channel   Direction  Words carried
//   req_chan  in         rx_byte, one received byte
//   rsp_chan  out        frame_byte, frame_last of a verified frame
//   csr_chan  in         reg_index, wr_data; always ready
//
// A received byte is taken whenever it is valid outside readout, so bytes may arrive back to back.
// After a matching checksum byte the stored frame of 4+L words is read out of
// the single-port frame store at one word per cycle while the output is taken,
// and input is held off until the last read is issued.
// Reset is synchronous; the frame store is not cleared.
// A stalled output holds its word and stalls the readout.
`timescale 1ns / 1ps

module serial_frame_receiver_checksum_core #(
   parameter int MAX_FRAME = 64
) (
   input  logic      clock,
   input  logic      reset,
   sfr_req_if.sink   req_chan,
   sfr_rsp_if.source rsp_chan,
   sfr_csr_if.sink   csr_chan
);

   sfr_pkg::cmd_type    cmd;
   sfr_pkg::status_type status;

   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sfr_datapath #(
      .MAX_FRAME (MAX_FRAME)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .rx_byte   (req_chan.rx_byte),
      .csr_valid (csr_chan.valid),
      .csr_ready (csr_chan.ready),
      .csr_index (csr_chan.reg_index),
      .csr_data  (csr_chan.wr_data),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_byte  (rsp_chan.frame_byte),
      .rsp_last  (rsp_chan.frame_last)
   );

endmodule

### hw/rtl/sfr_ctrl.sv
// Frame parsing state machine that sequences the datapath.
`timescale 1ns / 1ps

module sfr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sfr_pkg::status_type  status,
   output sfr_pkg::cmd_type     cmd
);

   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_TYPE = 3'd1;
   localparam logic [2:0] PH_LEN_LO = 3'd2;
   localparam logic [2:0] PH_LEN_HI = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;
   localparam logic [2:0] PH_CHECK = 3'd5;
   localparam logic [2:0] PH_READOUT = 3'd6;

   logic [2:0] phase_ff;
   logic [2:0] phase_in;
   logic       take;

   assign req_ready = (phase_ff != PH_READOUT);
   assign take = req_valid && req_ready;

   always_comb begin
      cmd.take = take;
      cmd.rd_go = (phase_ff == PH_READOUT);
      cmd.op = sfr_pkg::OP_HEADER;
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_TYPE: begin
            cmd.op = sfr_pkg::OP_TYPE;
            if (take) begin
               phase_in = status.type_hit ? PH_LEN_LO : PH_HUNT;
            end
         end
         PH_LEN_LO: begin
            cmd.op = sfr_pkg::OP_LEN_LO;
            if (take) begin
               phase_in = PH_LEN_HI;
            end
         end
         PH_LEN_HI: begin
            cmd.op = sfr_pkg::OP_LEN_HI;
            if (take) begin
               if (status.len_bad) begin
                  phase_in = PH_HUNT;
               end else if (status.len_one) begin
                  phase_in = PH_CHECK;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            cmd.op = sfr_pkg::OP_DATA;
            if (take && status.data_last) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            cmd.op = sfr_pkg::OP_CHECK;
            if (take) begin
               phase_in = status.sum_hit ? PH_READOUT : PH_HUNT;
            end
         end
         PH_READOUT: begin
            if (status.rd_last) begin
               phase_in = PH_HUNT;
            end
         end
         default: begin
            cmd.op = sfr_pkg::OP_HEADER;
            if (take) begin
               phase_in = status.header_hit ? PH_TYPE : PH_HUNT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

### hw/rtl/sfr_datapath.sv
// Frame store, running sum, length tracking, registers and output word register.
`timescale 1ns / 1ps

module sfr_datapath #(
   parameter int MAX_FRAME = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sfr_pkg::cmd_type              cmd,
   output sfr_pkg::status_type           status,
   input  logic [sfr_pkg::BYTE_W-1:0]    rx_byte,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sfr_pkg::BYTE_W-1:0]    csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sfr_pkg::BYTE_W-1:0]    rsp_byte,
   output logic                          rsp_last
);

   localparam int AW = $clog2(MAX_FRAME);

   logic [sfr_pkg::BYTE_W-1:0] mem [MAX_FRAME];

   logic [sfr_pkg::BYTE_W-1:0] header_ff;
   logic [sfr_pkg::BYTE_W-1:0] type_ff;
   logic [sfr_pkg::BYTE_W-1:0] sum_ff;
   logic [sfr_pkg::BYTE_W-1:0] sum_in;
   logic [sfr_pkg::BYTE_W-1:0] len_lo_ff;
   logic [AW-1:0]              len_ff;
   logic [AW-1:0]              count_ff;
   logic [AW-1:0]              rd_addr_ff;
   logic [AW-1:0]              wr_addr;
   logic [AW-1:0]              last_addr;
   logic [15:0]                len_full;
   logic [sfr_pkg::BYTE_W-1:0] rd_data_ff;
   logic                       rd_tag_ff;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic                       rd_issue;
   logic                       rd_at_end;

   assign csr_ready = 1'b1;
   assign len_full = {rx_byte, len_lo_ff};
   assign last_addr = len_ff + AW'(3);
   assign rd_at_end = (rd_addr_ff == last_addr);
   assign rd_issue = cmd.rd_go && (!out_valid_ff || rsp_ready);
   assign out_valid_in = rd_issue || (out_valid_ff && !rsp_ready);

   assign status.header_hit = (rx_byte == header_ff);
   assign status.type_hit = (rx_byte == type_ff);
   assign status.len_bad = (len_full == 16'd0) || (len_full > 16'(MAX_FRAME - 4));
   assign status.len_one = (len_full == 16'd1);
   assign status.data_last = ((count_ff + AW'(1)) == (len_ff - AW'(1)));
   assign status.sum_hit = (sum_ff == rx_byte);
   assign status.rd_last = rd_issue && rd_at_end;

   assign rsp_valid = out_valid_ff;
   assign rsp_byte = rd_data_ff;
   assign rsp_last = rd_tag_ff;

   always_comb begin
      wr_addr = '0;
      sum_in = sum_ff + rx_byte;
      case (cmd.op)
         sfr_pkg::OP_TYPE: wr_addr = AW'(1);
         sfr_pkg::OP_LEN_LO: wr_addr = AW'(2);
         sfr_pkg::OP_LEN_HI: wr_addr = AW'(3);
         sfr_pkg::OP_DATA: wr_addr = AW'(4) + count_ff;
         sfr_pkg::OP_CHECK: wr_addr = last_addr;
         default: begin
            wr_addr = '0;
            sum_in = rx_byte;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         mem[wr_addr] <= rx_byte;
      end
      if (rd_issue) begin
         rd_data_ff <= mem[rd_addr_ff];
         rd_tag_ff <= rd_at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         if (cmd.op == sfr_pkg::OP_LEN_LO) begin
            len_lo_ff <= rx_byte;
         end
         if (cmd.op == sfr_pkg::OP_LEN_HI) begin
            len_ff <= len_full[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= sfr_pkg::HEADER_RESET;
         type_ff <= sfr_pkg::TYPE_RESET;
         sum_ff <= '0;
         count_ff <= '0;
         rd_addr_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == sfr_pkg::REG_HEADER) begin
               header_ff <= csr_data;
            end else if (csr_index == sfr_pkg::REG_TYPE) begin
               type_ff <= csr_data;
            end
         end
         if (cmd.take) begin
            sum_ff <= sum_in;
            if (cmd.op == sfr_pkg::OP_DATA) begin
               count_ff <= count_ff + AW'(1);
            end else begin
               count_ff <= '0;
            end
         end
         if (cmd.take && cmd.op == sfr_pkg::OP_CHECK) begin
            rd_addr_ff <= '0;
         end else if (rd_issue) begin
            rd_addr_ff <= rd_addr_ff + AW'(1);
         end
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

### hw/rtl/sfr_checker.sv
// Port-level assertions for the serial frame receiver, bound to the top level.
`timescale 1ns / 1ps

module sfr_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [sfr_pkg::BYTE_W-1:0] rsp_byte,
   input logic                       rsp_last,
   input logic                       csr_ready
);

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Output word valid right after reset.");

   a_input_held_in_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !req_ready)
      else $error("Input taken while a frame is being read out.");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> !rsp_valid)
      else $error("Output word follows the last word of a frame at once.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_byte) && $stable(rsp_last)))
      else $error("Stalled output word changed or dropped.");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("Register write port not ready.");

endmodule

bind serial_frame_receiver_checksum_core sfr_checker u_sfr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_byte  (rsp_chan.frame_byte),
   .rsp_last  (rsp_chan.frame_last),
   .csr_ready (csr_chan.ready)
);
